// File: sv/gbn_pkg.sv
// shared types for the go-back-n arq endpoint
// event selectors, result kinds and the result control group
// no dependencies
package gbn_pkg;

   // event carried by an input transaction
   typedef enum logic [1:0] {
      MODE_PACKET  = 2'd0,
      MODE_FRAME   = 2'd1,
      MODE_CHKERR  = 2'd2,
      MODE_TIMEOUT = 2'd3
   } mode_type;

   // what a result transaction reports
   typedef enum logic [1:0] {
      KIND_SENT      = 2'd0,
      KIND_DELIVERED = 2'd1,
      KIND_NONE      = 2'd2,
      KIND_REJECTED  = 2'd3
   } kind_type;

   // control part of one result
   typedef struct packed {
      kind_type kind;
      logic     window_open;
      logic     last;
   } res_ctl_type;

endpackage

// File: sv/gbn_sbuf.sv
// send buffer: one write port, one read port, registered read data
// standalone, no package dependency
module gbn_sbuf #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/gbn_ctrl.sv
// event sequencer of the go-back-n endpoint: window pointers, ack handling
// and the resend walk over the send buffer; uses gbn_pkg
module gbn_ctrl import gbn_pkg::*; #(
   parameter int MAX_SEQ_NUM = 7,
   parameter int DATA_WIDTH  = 32,
   parameter int SEQ_W       = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   // input transaction
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mode_type              req_mode,
   input  logic [DATA_WIDTH-1:0] req_data,
   input  logic [SEQ_W-1:0]      req_seq,
   input  logic [SEQ_W-1:0]      req_ack,
   // send buffer
   output logic                  mem_we,
   output logic [SEQ_W-1:0]      mem_waddr,
   output logic [DATA_WIDTH-1:0] mem_wdata,
   output logic                  mem_re,
   output logic [SEQ_W-1:0]      mem_raddr,
   input  logic [DATA_WIDTH-1:0] mem_rdata,
   // result towards the output register
   output logic                  res_valid,
   input  logic                  res_ready,
   output res_ctl_type           res_ctl,
   output logic [SEQ_W-1:0]      res_seq,
   output logic [SEQ_W-1:0]      res_ack,
   output logic [DATA_WIDTH-1:0] res_data
);

   localparam int SEQ_SPACE = MAX_SEQ_NUM + 1;
   localparam logic [SEQ_W-1:0] MAX_S   = SEQ_W'(MAX_SEQ_NUM);
   localparam logic [SEQ_W:0]   SPACE_W = (SEQ_W + 1)'(SEQ_SPACE);
   localparam logic [SEQ_W:0]   MAX_W   = (SEQ_W + 1)'(MAX_SEQ_NUM);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SEND} state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [SEQ_W-1:0]      fseq_ff, fseq_in;
   logic [SEQ_W-1:0]      fack_ff, fack_in;
   logic [SEQ_W-1:0]      next_ff, next_in;
   logic [SEQ_W-1:0]      oldest_ff, oldest_in;
   logic [SEQ_W-1:0]      expect_ff, expect_in;
   logic [SEQ_W-1:0]      count_ff, count_in;
   logic [SEQ_W-1:0]      left_ff, left_in;

   logic [SEQ_W-1:0] ack_field;
   logic [SEQ_W:0]   span_w;
   logic [SEQ_W-1:0] span;
   logic             ack_ok;
   logic [SEQ_W-1:0] freed;
   logic [SEQ_W:0]   adv_sum;
   logic [SEQ_W-1:0] oldest_adv;
   logic [SEQ_W-1:0] cnt_after;
   logic             deliver;
   logic             full;
   logic             wo_now;

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
      return (s == MAX_S) ? '0 : s + SEQ_W'(1);
   endfunction

   function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
      logic [SEQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SPACE_W) begin
         s = s - SPACE_W;
      end
      return s[SEQ_W-1:0];
   endfunction

   // datapath shared by the event arms
   always_comb begin
      ack_field  = (expect_ff == '0) ? MAX_S : expect_ff - SEQ_W'(1);
      // circular distance from the oldest outstanding frame to the ack
      span_w     = {1'b0, fack_ff} + ((fack_ff < oldest_ff) ? SPACE_W : '0)
                   - {1'b0, oldest_ff};
      span       = span_w[SEQ_W-1:0];
      ack_ok     = {1'b0, fack_ff} < SPACE_W;
      // ack lies inside the outstanding run: free up to and including it
      freed      = (ack_ok && (span < count_ff)) ? span + SEQ_W'(1) : '0;
      adv_sum    = {1'b0, oldest_ff} + {1'b0, freed};
      oldest_adv = (adv_sum >= SPACE_W) ? SEQ_W'(adv_sum - SPACE_W)
                                        : adv_sum[SEQ_W-1:0];
      cnt_after  = count_ff - freed;
      deliver    = (fseq_ff == expect_ff);
      full       = (count_ff == MAX_S);
      wo_now     = !full;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      data_in   = data_ff;
      fseq_in   = fseq_ff;
      fack_in   = fack_ff;
      next_in   = next_ff;
      oldest_in = oldest_ff;
      expect_in = expect_ff;
      count_in  = count_ff;
      left_in   = left_ff;

      req_ready = (state_ff == ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = next_ff;
      mem_wdata = data_ff;
      mem_re    = 1'b0;
      mem_raddr = next_ff;

      res_valid           = 1'b0;
      res_ctl.kind        = KIND_NONE;
      res_ctl.window_open = wo_now;
      res_ctl.last        = 1'b1;
      res_seq             = '0;
      res_ack             = '0;
      res_data            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               data_in  = req_data;
               fseq_in  = req_seq;
               fack_in  = req_ack;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (mode_ff)
               MODE_PACKET: begin
                  res_valid = 1'b1;
                  if (full) begin
                     res_ctl.kind        = KIND_REJECTED;
                     res_ctl.window_open = 1'b0;
                  end else begin
                     res_ctl.kind        = KIND_SENT;
                     res_ctl.window_open = ({1'b0, count_ff} + (SEQ_W + 1)'(1)) < MAX_W;
                     res_seq             = next_ff;
                     res_ack             = ack_field;
                     res_data            = data_ff;
                  end
                  if (res_ready) begin
                     state_in = ST_IDLE;
                     if (!full) begin
                        mem_we   = 1'b1;
                        next_in  = seq_inc(next_ff);
                        count_in = count_ff + SEQ_W'(1);
                     end
                  end
               end
               MODE_FRAME: begin
                  res_valid           = 1'b1;
                  res_ctl.kind        = deliver ? KIND_DELIVERED : KIND_NONE;
                  res_ctl.window_open = cnt_after != MAX_S;
                  res_data            = deliver ? data_ff : '0;
                  if (res_ready) begin
                     state_in  = ST_IDLE;
                     expect_in = deliver ? seq_inc(expect_ff) : expect_ff;
                     oldest_in = oldest_adv;
                     count_in  = cnt_after;
                  end
               end
               MODE_CHKERR: begin
                  res_valid = 1'b1;
                  if (res_ready) begin
                     state_in = ST_IDLE;
                  end
               end
               MODE_TIMEOUT: begin
                  if (count_ff == '0) begin
                     res_valid = 1'b1;
                     if (res_ready) begin
                        next_in  = oldest_ff;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     // go back: fetch the oldest outstanding frame
                     next_in   = oldest_ff;
                     mem_re    = 1'b1;
                     mem_raddr = oldest_ff;
                     left_in   = count_ff;
                     state_in  = ST_SEND;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SEND: begin
            res_valid    = 1'b1;
            res_ctl.kind = KIND_SENT;
            res_ctl.last = (left_ff == SEQ_W'(1));
            res_seq      = next_ff;
            res_ack      = ack_field;
            res_data     = mem_rdata;
            if (res_ready) begin
               next_in = seq_inc(next_ff);
               left_in = left_ff - SEQ_W'(1);
               if (left_ff == SEQ_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  // read data holds while stalled; advance only on a taken result
                  mem_re    = 1'b1;
                  mem_raddr = seq_inc(next_ff);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         next_ff   <= '0;
         oldest_ff <= '0;
         expect_ff <= '0;
         count_ff  <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         next_ff   <= next_in;
         oldest_ff <= oldest_in;
         expect_ff <= expect_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
      end
      mode_ff <= mode_in;
      data_ff <= data_in;
      fseq_ff <= fseq_in;
      fack_ff <= fack_in;
   end

   // between events the send pointer sits just past the outstanding run
   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (next_ff == seq_add(oldest_ff, count_ff)))
      else $error("send pointer out of step with window");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= MAX_W)
      else $error("buffered count beyond window");

   a_send_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (left_ff != '0))
      else $error("resend walk with nothing left");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && res_ready && left_ff == SEQ_W'(1)) |=>
      (state_ff == ST_IDLE))
      else $error("resend walk did not end on last frame");

   a_accept_execs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction not executed");

endmodule

// File: sv/go_back_n_arq_endpoint.sv
// go-back-n arq endpoint: one event per input transaction, send buffer in a
// synchronous memory with registered read data. new packet, frame arrival,
// checksum error and empty timeout give one result each, held in the output
// register. timeout with n buffered frames: n resent frames, one per cycle
// from the buffer read port while the result side keeps up; no new event is taken until idle.
// reset (synchronous, active high) clears the window pointers; buffer undefined
// top level: uses gbn_pkg, gbn_ctrl and gbn_sbuf
module go_back_n_arq_endpoint import gbn_pkg::*; #(
   parameter  int MAX_SEQ_NUM = 7,
   parameter  int DATA_WIDTH  = 32,
   localparam int SEQ_W       = $clog2(MAX_SEQ_NUM + 1),
   localparam int IN_W        = ((DATA_WIDTH + 2 * SEQ_W + 7) / 8) * 8,
   localparam int OUT_W       = ((2 * SEQ_W + DATA_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // input events
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,  // packet_data, frame_seq, frame_ack, zero fill
   input  logic [1:0]       req_tuser,  // mode
   // results
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,  // out_seq, out_ack, out_data, window_open, zero fill
   output logic [1:0]       rsp_tuser,  // out_kind
   output logic             rsp_tlast   // last result of this event
);

   localparam int SEQ_SPACE = MAX_SEQ_NUM + 1;

   // sequencer to send buffer
   logic                  mem_we;
   logic [SEQ_W-1:0]      mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [SEQ_W-1:0]      mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   // sequencer to output register
   logic                  res_valid;
   logic                  res_ready;
   res_ctl_type           res_ctl;
   logic [SEQ_W-1:0]      res_seq;
   logic [SEQ_W-1:0]      res_ack;
   logic [DATA_WIDTH-1:0] res_data;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   res_ctl_type           rsp_ctl_ff;
   logic [SEQ_W-1:0]      rsp_seq_ff;
   logic [SEQ_W-1:0]      rsp_ack_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;

   gbn_ctrl #(
      .MAX_SEQ_NUM (MAX_SEQ_NUM),
      .DATA_WIDTH  (DATA_WIDTH),
      .SEQ_W       (SEQ_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (mode_type'(req_tuser)),
      .req_data  (req_tdata[DATA_WIDTH-1:0]),
      .req_seq   (req_tdata[DATA_WIDTH+SEQ_W-1:DATA_WIDTH]),
      .req_ack   (req_tdata[DATA_WIDTH+2*SEQ_W-1:DATA_WIDTH+SEQ_W]),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_ctl   (res_ctl),
      .res_seq   (res_seq),
      .res_ack   (res_ack),
      .res_data  (res_data)
   );

   // one entry per sequence number
   gbn_sbuf #(
      .DEPTH (SEQ_SPACE),
      .WIDTH (DATA_WIDTH),
      .AW    (SEQ_W)
   ) u_sbuf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register parts the sequencer from a stalled result side
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload loads only on a taken result
      if (res_valid && res_ready) begin
         rsp_ctl_ff  <= res_ctl;
         rsp_seq_ff  <= res_seq;
         rsp_ack_ff  <= res_ack;
         rsp_data_ff <= res_data;
      end
   end

   // pack the result transaction
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[SEQ_W-1:0]                    = rsp_seq_ff;
      rsp_tdata[2*SEQ_W-1:SEQ_W]              = rsp_ack_ff;
      rsp_tdata[2*SEQ_W+DATA_WIDTH-1:2*SEQ_W] = rsp_data_ff;
      rsp_tdata[2*SEQ_W+DATA_WIDTH]           = rsp_ctl_ff.window_open;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ctl_ff.kind;
   assign rsp_tlast  = rsp_ctl_ff.last;

endmodule
